/* sv/xpdl_pkg.sv */
// shared types, constants and helpers of the binary dense layer
package xpdl_pkg;

    // widest weight row the datapath is built for
    localparam int ROW_BITS = 128;
    // entries in the queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PW = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

    // stream payload widths
    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 40;

    // input tdata field positions
    localparam int S_IDX_LSB = 0;
    localparam int S_LOW_LSB = 7;
    localparam int S_HIGH_LSB = 71;
    localparam int S_SCALE_LSB = 135;
    localparam int S_BIAS_LSB = 151;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_ACTIVE_BITS  = 2'd0,
        REG_BIAS_ENABLE  = 2'd1,
        REG_OUTPUT_COUNT = 2'd2,
        REG_TOKEN_COUNT  = 2'd3
    } xpdl_reg_t;

    // item kinds carried on tuser
    typedef enum logic {
        OP_COMPUTE = 1'b0,
        OP_LOAD    = 1'b1
    } xpdl_op_t;

    // configuration register set
    typedef struct packed {
        logic [7:0]  active_bits;
        logic        bias_enable;
        logic [7:0]  output_count;
        logic [10:0] token_count;
    } xpdl_cfg_t;

    // one classified compute item on its way to the back end
    typedef struct packed {
        logic [6:0]          neuron;
        logic [15:0]         scale;
        logic [15:0]         bias;
        logic [ROW_BITS-1:0] match;
    } xpdl_entry_t;

    // active bit count limited to the row width
    function automatic logic [7:0] xpdl_clamp(input logic [7:0] bits, input logic [7:0] lim);
        xpdl_clamp = (bits > lim) ? lim : bits;
    endfunction

endpackage

/* sv/xpdl_ram.sv */
// generic single write port ram with registered read
module xpdl_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 128
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, output holds between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/xpdl_front.sv */
// front end: takes transactions, writes the weight table, forms match vectors
module xpdl_front #(
    parameter int MAX_IN_BITS = 128,
    parameter int MAX_NEURONS = 128
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_fire,
    input  logic [xpdl_pkg::S_TDATA_W-1:0]    in_data,
    input  logic                              in_op,
    input  logic [7:0]                        active_bits,
    output logic                              push_valid,
    output xpdl_pkg::xpdl_entry_t             push_entry
);
    import xpdl_pkg::*;

    localparam int AW = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
    localparam int RW = MAX_IN_BITS + 32;

    logic [6:0]              in_idx;
    logic [ROW_BITS-1:0]     in_row;
    logic [15:0]             in_scale;
    logic [15:0]             in_bias;
    logic                    in_table;
    logic                    is_load;
    logic                    ram_we;
    logic                    ram_re;
    logic [RW-1:0]           ram_wdata;
    logic [RW-1:0]           ram_rdata;

    logic                    a_valid_reg;
    logic                    a_hit_reg;
    logic [6:0]              a_neuron_reg;
    logic [MAX_IN_BITS-1:0]  a_act_reg;

    logic [7:0]              n_bits;
    logic [MAX_IN_BITS-1:0]  mask;
    logic [MAX_IN_BITS-1:0]  weights;
    logic [MAX_IN_BITS-1:0]  match;

    // field unpacking and classification
    assign in_idx   = in_data[S_IDX_LSB +: 7];
    assign in_row   = {in_data[S_HIGH_LSB +: 64], in_data[S_LOW_LSB +: 64]};
    assign in_scale = in_data[S_SCALE_LSB +: 16];
    assign in_bias  = in_data[S_BIAS_LSB +: 16];
    assign in_table = {1'b0, in_idx} < 8'(MAX_NEURONS);
    assign is_load  = xpdl_op_t'(in_op) == OP_LOAD;

    // loads write the table, computes read it
    assign ram_we    = in_fire && is_load && in_table;
    assign ram_re    = in_fire && !is_load && in_table;
    assign ram_wdata = {in_bias, in_scale, in_row[MAX_IN_BITS-1:0]};

    xpdl_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_NEURONS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (in_idx[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (in_idx[AW-1:0]),
        .rdata (ram_rdata)
    );

    // compute stage alongside the table read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= in_fire && !is_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            a_hit_reg    <= in_table;
            a_neuron_reg <= in_idx;
            a_act_reg    <= in_row[MAX_IN_BITS-1:0];
        end
    end

    // active bit mask
    assign n_bits = xpdl_clamp(active_bits, 8'(MAX_IN_BITS));

    always_comb begin
        for (int i = 0; i < MAX_IN_BITS; i++) begin
            mask[i] = 8'(i) < n_bits;
        end
    end

    // rows beyond the table count against zero weights
    assign weights = a_hit_reg ? ram_rdata[MAX_IN_BITS-1:0] : '0;
    assign match   = mask & ~(a_act_reg ^ weights);

    assign push_valid       = a_valid_reg;
    assign push_entry.neuron = a_neuron_reg;
    assign push_entry.scale  = a_hit_reg ? ram_rdata[MAX_IN_BITS +: 16] : 16'd0;
    assign push_entry.bias   = a_hit_reg ? ram_rdata[MAX_IN_BITS + 16 +: 16] : 16'd0;
    assign push_entry.match  = ROW_BITS'(match);

endmodule

/* sv/xpdl_queue.sv */
// short queue between front and back
module xpdl_queue (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                push,
    input  xpdl_pkg::xpdl_entry_t               push_entry,
    input  logic                                pop,
    output xpdl_pkg::xpdl_entry_t               pop_entry,
    output logic                                empty,
    output logic [xpdl_pkg::QUEUE_CW-1:0]       count
);
    import xpdl_pkg::*;

    xpdl_entry_t           mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0]   wr_ptr_reg;
    logic [QUEUE_PW-1:0]   rd_ptr_reg;
    logic [QUEUE_CW-1:0]   count_reg;
    logic [QUEUE_CW-1:0]   count_next;

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill level
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign pop_entry = mem_reg[rd_ptr_reg];
    assign empty     = count_reg == '0;
    assign count     = count_reg;

endmodule

/* sv/xpdl_back.sv */
// back end: popcount, scale and bias, row marks and output register
module xpdl_back #(
    parameter int MAX_IN_BITS = 128
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  xpdl_pkg::xpdl_cfg_t               cfg,
    input  logic                              q_empty,
    input  xpdl_pkg::xpdl_entry_t             q_entry,
    output logic                              q_pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [xpdl_pkg::M_TDATA_W-1:0]    m_data,
    output logic                              m_lot,
    output logic                              m_lol
);
    import xpdl_pkg::*;

    localparam int LVLS = $clog2(ROW_BITS);

    logic               advance;
    logic [7:0]         lvl [LVLS+1][ROW_BITS];
    logic [7:0]         cnt_c;
    logic [7:0]         n_bits;
    logic signed [9:0]  dot_c;
    logic signed [25:0] prod_c;
    logic signed [25:0] sum_c;
    logic               lot_c;
    logic               lol_c;

    logic               b1_valid_reg;
    logic [6:0]         b1_neuron_reg;
    logic signed [15:0] b1_scale_reg;
    logic signed [15:0] b1_bias_reg;
    logic [7:0]         b1_cnt_reg;

    logic               b2_valid_reg;
    logic [6:0]         b2_neuron_reg;
    logic signed [25:0] b2_prod_reg;
    logic signed [15:0] b2_bias_reg;
    logic [7:0]         b2_cnt_reg;

    logic               out_valid_reg;
    logic [6:0]         out_neuron_reg;
    logic [23:0]        out_value_reg;
    logic               out_sign_reg;
    logic [7:0]         out_cnt_reg;
    logic               out_lot_reg;
    logic               out_lol_reg;

    logic [9:0]         token_reg;
    logic [9:0]         token_next;

    // whole back pipeline moves when the output register is free
    assign advance = !out_valid_reg || m_ready;
    assign q_pop   = advance && !q_empty;

    // popcount adder tree
    always_comb begin
        for (int l = 0; l <= LVLS; l++) begin
            for (int i = 0; i < ROW_BITS; i++) begin
                lvl[l][i] = 8'd0;
            end
        end
        for (int i = 0; i < ROW_BITS; i++) begin
            lvl[0][i] = {7'd0, q_entry.match[i]};
        end
        for (int l = 1; l <= LVLS; l++) begin
            for (int i = 0; i < (ROW_BITS >> l); i++) begin
                lvl[l][i] = lvl[l-1][2*i] + lvl[l-1][2*i+1];
            end
        end
        cnt_c = lvl[LVLS][0];
    end

    // signed dot product and scale
    assign n_bits = xpdl_clamp(cfg.active_bits, 8'(MAX_IN_BITS));
    assign dot_c  = $signed({1'b0, b1_cnt_reg, 1'b0}) - $signed({2'b00, n_bits});
    assign prod_c = 26'(b1_scale_reg) * 26'(dot_c);

    // bias and row marks
    assign sum_c = b2_prod_reg + (cfg.bias_enable ? 26'(b2_bias_reg) : 26'sd0);
    assign lot_c = {1'b0, b2_neuron_reg} == (cfg.output_count - 8'd1);
    assign lol_c = lot_c && ({1'b0, token_reg} == (cfg.token_count - 11'd1));

    always_comb begin
        token_next = token_reg;
        if (lol_c) begin
            token_next = '0;
        end else if (lot_c) begin
            token_next = token_reg + 10'd1;
        end
    end

    // valid bits and token counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            token_reg     <= '0;
        end else if (advance) begin
            b1_valid_reg  <= q_pop;
            b2_valid_reg  <= b1_valid_reg;
            out_valid_reg <= b2_valid_reg;
            if (b2_valid_reg) begin
                token_reg <= token_next;
            end
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (advance) begin
            b1_neuron_reg  <= q_entry.neuron;
            b1_scale_reg   <= q_entry.scale;
            b1_bias_reg    <= q_entry.bias;
            b1_cnt_reg     <= cnt_c;

            b2_neuron_reg  <= b1_neuron_reg;
            b2_prod_reg    <= prod_c;
            b2_bias_reg    <= b1_bias_reg;
            b2_cnt_reg     <= b1_cnt_reg;

            out_neuron_reg <= b2_neuron_reg;
            out_value_reg  <= sum_c[23:0];
            out_sign_reg   <= !sum_c[25];
            out_cnt_reg    <= b2_cnt_reg;
            out_lot_reg    <= lot_c;
            out_lol_reg    <= lol_c;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = {out_cnt_reg, out_sign_reg, out_value_reg, out_neuron_reg};
    assign m_lot   = out_lot_reg;
    assign m_lol   = out_lol_reg;

endmodule

/* sv/xnor_popcount_dense_layer.sv */
// Computes pass the front register, queue, b1, b2 and output register; loads write the table.
// Throughput: one transaction per cycle while s_tready is high, loads and computes mixed,
//   with the table read, the popcount tree and the 16x10 multiply in separate stages.
// A queue of 4 entries lets the input side keep going while a result waits on m_tready.
// Reset (aresetn low, synchronous): registers take their defaults, token counter and queue
//   clear; the weight table is not cleared and holds nothing until rows are loaded.
module xnor_popcount_dense_layer #(
    parameter int MAX_IN_BITS = 128,
    parameter int MAX_NEURONS = 128
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [10:0]                       cfg_wdata,
    // tdata: neuron_index, bits_low, bits_high, scale_in, bias_in, 1 bit pad
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [xpdl_pkg::S_TDATA_W-1:0]    s_tdata,
    // tuser: operation
    input  logic                              s_tuser,
    // tdata: neuron_out, value, sign_bit, match_count
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [xpdl_pkg::M_TDATA_W-1:0]    m_tdata,
    // tuser: last_of_token
    output logic                              m_tuser,
    // tlast: last_of_layer
    output logic                              m_tlast
);
    import xpdl_pkg::*;

    xpdl_cfg_t            cfg_reg;
    logic                 in_fire;
    logic                 push_valid;
    xpdl_entry_t          push_entry;
    logic                 q_pop;
    xpdl_entry_t          q_entry;
    logic                 q_empty;
    logic [QUEUE_CW-1:0]  q_count;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_bits  <= 8'd30;
            cfg_reg.bias_enable  <= 1'b1;
            cfg_reg.output_count <= 8'd128;
            cfg_reg.token_count  <= 11'd50;
        end else if (cfg_we) begin
            unique case (xpdl_reg_t'(cfg_index))
                REG_ACTIVE_BITS:  cfg_reg.active_bits  <= cfg_wdata[7:0];
                REG_BIAS_ENABLE:  cfg_reg.bias_enable  <= cfg_wdata[0];
                REG_OUTPUT_COUNT: cfg_reg.output_count <= cfg_wdata[7:0];
                REG_TOKEN_COUNT:  cfg_reg.token_count  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // accept while the queue can take everything in flight
    assign s_tready = ({1'b0, q_count} + {{QUEUE_CW{1'b0}}, push_valid})
                      < (QUEUE_CW + 1)'(QUEUE_DEPTH);
    assign in_fire  = s_tvalid && s_tready;

    xpdl_front #(
        .MAX_IN_BITS (MAX_IN_BITS),
        .MAX_NEURONS (MAX_NEURONS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .in_data     (s_tdata),
        .in_op       (s_tuser),
        .active_bits (cfg_reg.active_bits),
        .push_valid  (push_valid),
        .push_entry  (push_entry)
    );

    xpdl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push_valid),
        .push_entry (push_entry),
        .pop        (q_pop),
        .pop_entry  (q_entry),
        .empty      (q_empty),
        .count      (q_count)
    );

    xpdl_back #(
        .MAX_IN_BITS (MAX_IN_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (m_tdata),
        .m_lot   (m_tuser),
        .m_lol   (m_tlast)
    );

    // queue never holds more than its depth, counting the item on its way in
    assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, q_count} + {{QUEUE_CW{1'b0}}, push_valid}) <= (QUEUE_CW + 1)'(QUEUE_DEPTH))
        else $error("queue credit overrun");

    // input stalls only when the queue is close to full
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_count >= QUEUE_CW'(QUEUE_DEPTH - 1))
        else $error("input stalled with queue room");

    // end of layer is always also end of a token row
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("layer end without row end");

    // a popped entry passes b1 and b2 into the output register when nothing stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result lost in back pipeline");

endmodule
